[rtl/core/ring_sync_sequence_detector_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ring sync sequence detector
// Shared helpers for the concurrent checks bound to the top level.
// ----------------------------------------------------------------------------
`ifndef RING_SYNC_SEQUENCE_DETECTOR_ASSERT_SVH
`define RING_SYNC_SEQUENCE_DETECTOR_ASSERT_SVH

// Clocked check, quiet while reset is high
`define RSSD_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset
`define RSSD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/rssd_pkg.sv]
// ----------------------------------------------------------------------------
// rssd_pkg
// Types and fixed constants shared by the sync sequence detector modules.
// ----------------------------------------------------------------------------
package rssd_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned PATTERN_W = 64;
  localparam int unsigned OUT_W     = 24;

  // Command codes carried in s_tuser
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_ARM  = 1'b1
  } command_t;

  // Configuration register indexes
  typedef enum logic {
    REG_SYNC_LENGTH  = 1'b0,
    REG_SYNC_PATTERN = 1'b1
  } reg_index_t;

  // One input item
  typedef struct packed {
    command_t           command;
    logic [BYTE_W-1:0]  rx_byte;
  } item_t;

  // One result item
  typedef struct packed {
    logic               armed;
    logic [BYTE_W-1:0]  bytes_since_start;
    logic [BYTE_W-1:0]  message_start;
    logic               sync_found;
  } result_t;

  // Handshake between the pipeline stages
  typedef struct packed {
    logic advance;
  } stage_ctrl_t;

endpackage

[rtl/core/rssd_in_stage.sv]
// ----------------------------------------------------------------------------
// rssd_in_stage
// Input register: captures one transfer and holds it until it is processed.
// ----------------------------------------------------------------------------
module rssd_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,
  input  logic          s_tuser,
  input  logic          advance,
  output rssd_pkg::item_t item,
  output logic          valid
);
  import rssd_pkg::*;

  // Room when empty or when the held item leaves this cycle
  assign s_tready = !valid || advance;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.command <= command_t'(s_tuser);
      item.rx_byte <= s_tdata;
    end
  end

endmodule

[rtl/core/rssd_track.sv]
// ----------------------------------------------------------------------------
// rssd_track
// Sync tracker: ring write pointer, match counter, armed flag, start index
// and the configuration registers; forms the result for each item.
// ----------------------------------------------------------------------------
module rssd_track #(
  parameter int unsigned RING_SIZE = 256,
  parameter int unsigned MAX_SYNC  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [rssd_pkg::PATTERN_W-1:0] cfg_data,
  input  logic                          advance,
  input  rssd_pkg::item_t               item,
  output rssd_pkg::result_t             result
);
  import rssd_pkg::*;

  localparam int unsigned PTR_W  = (RING_SIZE > 2) ? $clog2(RING_SIZE) : 1;
  localparam int unsigned WIDE_W = PTR_W + 1;
  localparam logic [PTR_W-1:0]  RING_LAST = PTR_W'(RING_SIZE - 1);
  localparam logic [WIDE_W-1:0] RING_FULL = WIDE_W'(RING_SIZE);
  localparam logic [LEN_W-1:0]  SYNC_CAP  = LEN_W'(MAX_SYNC);

  // Sequence length reduced modulo the ring size (at most eight subtracts)
  function automatic logic [LEN_W-1:0] len_mod(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] d;
    d = len;
    for (int i = 0; i < 8; i++) begin
      if (int'(d) >= int'(RING_SIZE)) d = d - LEN_W'(RING_SIZE);
    end
    return d;
  endfunction

  // Ring distance a - b, modulo the ring size
  function automatic logic [PTR_W-1:0] ring_dist(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
    logic [WIDE_W-1:0] wa;
    logic [WIDE_W-1:0] wb;
    wa = WIDE_W'(a);
    wb = WIDE_W'(b);
    if (wa < wb) return PTR_W'(wa + (RING_FULL - wb));
    else         return PTR_W'(wa - wb);
  endfunction

  logic [LEN_W-1:0]     sync_length;
  logic [PATTERN_W-1:0] sync_pattern;
  logic [PTR_W-1:0]     write_pointer, write_pointer_next;
  logic [LEN_W-1:0]     match_count, match_count_next;
  logic                 waiting, waiting_next;
  logic [PTR_W-1:0]     start_index, start_index_next;
  logic                 found;

  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  cnt_base;
  logic [LEN_W-1:0]  cnt_inc;
  logic [BYTE_W-1:0] want;
  logic [PTR_W-1:0]  ptr_inc;
  logic [PTR_W-1:0]  back_len;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_length  <= '0;
      sync_pattern <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_SYNC_LENGTH:  sync_length  <= cfg_data[LEN_W-1:0];
        REG_SYNC_PATTERN: sync_pattern <= cfg_data;
        default: ;
      endcase
    end
  end

  // Compare and pointer arithmetic
  always_comb begin
    eff_len  = (sync_length > SYNC_CAP) ? SYNC_CAP : sync_length;
    cnt_base = (match_count >= eff_len) ? '0 : match_count;
    cnt_inc  = cnt_base + LEN_W'(1);
    want     = sync_pattern[{cnt_base[2:0], 3'b000} +: BYTE_W];
    ptr_inc  = (write_pointer == RING_LAST) ? '0 : write_pointer + PTR_W'(1);
    back_len = ring_dist(ptr_inc, PTR_W'(len_mod(eff_len)));
  end

  // Next state
  always_comb begin
    write_pointer_next = write_pointer;
    match_count_next   = match_count;
    waiting_next       = waiting;
    start_index_next   = start_index;
    found              = 1'b0;
    case (item.command)
      CMD_ARM: begin
        waiting_next = 1'b1;
      end
      CMD_BYTE: begin
        write_pointer_next = ptr_inc;
        if (waiting) begin
          if (eff_len == '0) begin
            waiting_next     = 1'b0;
            match_count_next = '0;
            start_index_next = write_pointer;
            found            = 1'b1;
          end else if (want == item.rx_byte) begin
            if (cnt_inc == eff_len) begin
              waiting_next     = 1'b0;
              match_count_next = '0;
              start_index_next = back_len;
              found            = 1'b1;
            end else begin
              match_count_next = cnt_inc;
            end
          end else begin
            match_count_next = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Result fields from the updated state
  always_comb begin
    result.sync_found        = found;
    result.message_start     = BYTE_W'(start_index_next);
    result.bytes_since_start = BYTE_W'(ring_dist(write_pointer_next, start_index_next));
    result.armed             = waiting_next;
  end

  // Tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      match_count   <= '0;
      waiting       <= 1'b0;
      start_index   <= '0;
    end else if (advance) begin
      write_pointer <= write_pointer_next;
      match_count   <= match_count_next;
      waiting       <= waiting_next;
      start_index   <= start_index_next;
    end
  end

endmodule

[rtl/core/rssd_out_stage.sv]
// ----------------------------------------------------------------------------
// rssd_out_stage
// Result register: holds one result until the master side takes it.
// ----------------------------------------------------------------------------
module rssd_out_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  rssd_pkg::result_t             result,
  output rssd_pkg::stage_ctrl_t         ctrl,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rssd_pkg::OUT_W-1:0]    m_tdata
);
  import rssd_pkg::*;

  result_t held;

  // An item moves on when the result register is free or draining
  assign ctrl.advance = in_valid && (!m_tvalid || m_tready);

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      held <= result;
    end
  end

  assign m_tdata = OUT_W'(held);

endmodule

[rtl/core/ring_sync_sequence_detector.sv]
// ----------------------------------------------------------------------------
// ring_sync_sequence_detector
// Sync word detector over a circular receive ring: tracks the ring write
// pointer, matches armed bytes against the sync sequence and reports where
// the sequence began.
//
//  Channel  Dir  Payload (low bit up)
//  s_*      in   tuser: command; tdata: rx_byte
//  m_*      out  tdata: sync_found, message_start, bytes_since_start, armed
//  cfg_*    in   cfg_index 0 = sync_length, 1 = sync_pattern
//
// One item per cycle sustained while m_tready stays high; the s transfer reaches
// m_tvalid through the input register, then the result register.
// All tracking is one byte compare, an increment and two ring distances per item.
// Reset (rst, synchronous) clears pointers, armed flag and configuration.
// A stalled m side holds the result; s_tready drops only when both
// registers are full.
// ----------------------------------------------------------------------------
module ring_sync_sequence_detector #(
  parameter int unsigned RING_SIZE = 256,
  parameter int unsigned MAX_SYNC  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [0] sync_found, [8:1] message_start,
                                 // [16:9] bytes_since_start, [17] armed
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import rssd_pkg::*;

  item_t       item;
  logic        item_valid;
  result_t     result;
  stage_ctrl_t ctrl;

  // Input register
  rssd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (ctrl.advance),
    .item     (item),
    .valid    (item_valid)
  );

  // Tracker and result logic
  rssd_track #(
    .RING_SIZE (RING_SIZE),
    .MAX_SYNC  (MAX_SYNC)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (ctrl.advance),
    .item      (item),
    .result    (result)
  );

  // Result register
  rssd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_valid),
    .result   (result),
    .ctrl     (ctrl),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

[rtl/core/rssd_checker.sv]
// ----------------------------------------------------------------------------
// rssd_checker
// Port-level checks on the sync sequence detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "ring_sync_sequence_detector_assert.svh"

module rssd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // A result waiting on the master side stays offered
  `RSSD_ASSERT(a_m_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped")

  // Nothing is offered right after reset
  `RSSD_ASSERT_ALWAYS(a_rst_idle, clk, rst |=> !m_tvalid, "m_tvalid high after reset")

  // Input only backs up when the result register is occupied
  `RSSD_ASSERT(a_stall_cause, clk, rst, !s_tready |-> m_tvalid, "input stalled, output empty")

  // A completed sync always disarms
  `RSSD_ASSERT(a_found_disarms, clk, rst, m_tvalid && m_tdata[0] |-> !m_tdata[17], "armed on sync")

endmodule

bind ring_sync_sequence_detector rssd_checker u_rssd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[dv/tb_ring_sync_sequence_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for ring_sync_sequence_detector
// Sends received bytes and arm commands through the stream input and checks
// every result against a local model of the ring pointer and the sync match,
// or against scripted values. The test starts with a scripted set of items
// covering the corner cases. It then runs random arm and sync-byte sequences,
// with some broken sequences and some noise, under several register settings.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_ring_sync_sequence_detector;
  import rssd_pkg::*;

  localparam int unsigned RING_SIZE = 256;
  localparam int unsigned MAX_SYNC  = 8;
  localparam int unsigned ITEMS     = 750;
  localparam int unsigned NSTEPS    = 29;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = CMD_BYTE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_SYNC_LENGTH;
  logic [63:0] cfg_data = '0;

  ring_sync_sequence_detector #(
    .RING_SIZE(RING_SIZE),
    .MAX_SYNC (MAX_SYNC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Model copy of the registers and tracking state
  logic [3:0]  sync_len_q = '0;
  logic [63:0] sync_pat_q = '0;
  logic [7:0]  ring_wr    = '0;
  logic [3:0]  hit_count  = '0;
  logic        hunting    = 1'b0;
  logic [7:0]  anchor     = '0;

  result_t     due_reports[$];
  int unsigned mismatches = 0;
  int unsigned accepted   = 0;
  bit          steady     = 1'b0;

  // Scripted stimulus: item rows and register writes
  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    command_t    cmd;
    reg_index_t  idx;
    logic [63:0] value;   // rx_byte or register value
    bit          typed;   // use the result below instead of the model
    result_t     given;   // {armed, bytes_since_start, message_start, sync_found}
  } step_t;

  step_t script [NSTEPS] = '{
    // after reset: plain byte, arm, then zero length fires on any byte
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'h00, 1'b1, {1'b0, 8'd1, 8'd0, 1'b0}},
    '{ROW_ITEM,  CMD_ARM,  REG_SYNC_LENGTH,  64'hA5, 1'b1, {1'b1, 8'd1, 8'd0, 1'b0}},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'hFF, 1'b1, {1'b0, 8'd1, 8'd1, 1'b1}},
    // length above the maximum saturates to eight bytes
    '{ROW_WRITE, CMD_BYTE, REG_SYNC_LENGTH,  64'h0F, 1'b0, '0},
    '{ROW_WRITE, CMD_BYTE, REG_SYNC_PATTERN, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
    '{ROW_ITEM,  CMD_ARM,  REG_SYNC_LENGTH,  64'h00, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'hEF, 1'b0, '0},
    // mismatch restarts without rechecking this byte
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'h00, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'hEF, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'hCD, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'hAB, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'h89, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'h67, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'h45, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'h23, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'h01, 1'b0, '0},
    // partial match of three, then length cut to two while armed
    '{ROW_ITEM,  CMD_ARM,  REG_SYNC_LENGTH,  64'h00, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'hEF, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'hCD, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'hAB, 1'b0, '0},
    '{ROW_WRITE, CMD_BYTE, REG_SYNC_LENGTH,  64'h02, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'hEF, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'hCD, 1'b0, '0},
    // single zero byte; arm twice in a row
    '{ROW_WRITE, CMD_BYTE, REG_SYNC_LENGTH,  64'h01, 1'b0, '0},
    '{ROW_WRITE, CMD_BYTE, REG_SYNC_PATTERN, 64'h00, 1'b0, '0},
    '{ROW_ITEM,  CMD_ARM,  REG_SYNC_LENGTH,  64'hFF, 1'b0, '0},
    '{ROW_ITEM,  CMD_ARM,  REG_SYNC_LENGTH,  64'h00, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'hFF, 1'b0, '0},
    '{ROW_ITEM,  CMD_BYTE, REG_SYNC_LENGTH,  64'h00, 1'b0, '0}
  };

  // Model: advance the ring pointer and the sync match for one item
  function automatic result_t track_sync_byte(command_t cmd, logic [7:0] rx);
    result_t    r;
    logic [3:0] eff;
    logic [7:0] nxt;
    r = '0;
    if (cmd == CMD_ARM) begin
      hunting = 1'b1;
    end else begin
      nxt = ring_wr + 8'd1;
      if (hunting) begin
        eff = (sync_len_q > MAX_SYNC) ? 4'(MAX_SYNC) : sync_len_q;
        if (eff == 0) begin
          hunting     = 1'b0;
          hit_count   = '0;
          anchor      = ring_wr;
          r.sync_found = 1'b1;
        end else begin
          // stale count after the length was reduced
          if (hit_count >= eff) hit_count = '0;
          if (sync_pat_q[8*int'(hit_count) +: 8] == rx) begin
            hit_count = hit_count + 4'd1;
            if (hit_count == eff) begin
              hunting      = 1'b0;
              hit_count    = '0;
              anchor       = nxt - 8'(eff);
              r.sync_found = 1'b1;
            end
          end else begin
            hit_count = '0;
          end
        end
      end
      ring_wr = nxt;
    end
    r.message_start     = anchor;
    r.bytes_since_start = ring_wr - anchor;
    r.armed             = hunting;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    $display("%0t: mismatch on %s, want %0h got %0h", $time, what, want, got);
    mismatches++;
  endtask

  // One input transfer; valid stays high into the next item unless a gap falls
  task automatic offer_item(input command_t cmd, input logic [7:0] rx,
                            input bit typed = 1'b0, input result_t given = '0);
    result_t r;
    while (!steady && $urandom_range(99) < 16) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= rx;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = track_sync_byte(cmd, rx);
    due_reports.push_back(typed ? given : r);
    accepted++;
  endtask

  // Register write once every result is back and the pipeline has emptied
  task automatic write_register(input reg_index_t idx, input logic [63:0] val);
    s_tvalid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_SYNC_LENGTH) sync_len_q = val[3:0];
    else sync_pat_q = val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Output side: check each transfer, stall at random
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[17:0];
      if (due_reports.size() == 0) begin
        flag_mismatch("unexpected result", 0, m_tdata);
      end else begin
        want = due_reports.pop_front();
        if (got.sync_found != want.sync_found)
          flag_mismatch("sync_found", want.sync_found, got.sync_found);
        if (got.message_start != want.message_start)
          flag_mismatch("message_start", want.message_start, got.message_start);
        if (got.bytes_since_start != want.bytes_since_start)
          flag_mismatch("bytes_since_start", want.bytes_since_start,
                        got.bytes_since_start);
        if (got.armed != want.armed)
          flag_mismatch("armed", want.armed, got.armed);
      end
    end
    m_tready <= steady || ($urandom_range(99) >= 16);
  end

  // Main sequence
  initial begin
    int unsigned target;
    int unsigned seqs;
    int unsigned eff;
    int unsigned cut;
    int unsigned guard;
    logic [3:0]  len;
    logic [63:0] pat;
    logic [7:0]  rx;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // scripted corner cases
    for (int i = 0; i < NSTEPS; i++) begin
      if (script[i].kind == ROW_WRITE)
        write_register(script[i].idx, script[i].value);
      else
        offer_item(script[i].cmd, script[i].value[7:0], script[i].typed,
                   script[i].given);
    end

    // long unarmed run so the distance wraps through a full ring
    for (int i = 0; i < RING_SIZE + 4; i++)
      offer_item(CMD_BYTE, 8'($urandom));

    // random sequences under changing settings, up to the total item count
    target = ITEMS;
    seqs   = 0;
    while (accepted < target) begin
      if (seqs % 8 == 0) begin
        case ($urandom_range(4))
          0:       len = 4'd0;
          1:       len = 4'(MAX_SYNC);
          2:       len = 4'd15;
          default: len = 4'($urandom_range(15, 1));
        endcase
        case ($urandom_range(3))
          0:       pat = '0;
          1:       pat = '1;
          default: pat = {$urandom, $urandom};
        endcase
        // upper bits of the length word are don't-care
        write_register(REG_SYNC_LENGTH, ({$urandom, $urandom} & ~64'hF) | 64'(len));
        write_register(REG_SYNC_PATTERN, pat);
      end
      steady = (accepted + 450 >= target) && (accepted + 300 < target);

      if ($urandom_range(99) < 15) begin
        // noise burst
        repeat ($urandom_range(8, 1))
          offer_item(($urandom_range(3) == 0) ? CMD_ARM : CMD_BYTE, 8'($urandom));
      end else begin
        eff = (sync_len_q > MAX_SYNC) ? MAX_SYNC : sync_len_q;
        cut = ($urandom_range(5) == 0) ? $urandom_range(eff) : eff + 1;
        offer_item(CMD_ARM, 8'($urandom));
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(2, 1)) offer_item(CMD_BYTE, 8'($urandom));
        for (int k = 0; k < eff; k++) begin
          rx = sync_pat_q[8*k +: 8];
          if (k == cut) rx = rx ^ 8'($urandom_range(255, 1));
          offer_item(CMD_BYTE, rx);
        end
        repeat ($urandom_range(5)) offer_item(CMD_BYTE, 8'($urandom));
      end
      seqs++;
    end
    steady = 1'b0;

    // drain
    s_tvalid <= 1'b0;
    guard = 0;
    while (due_reports.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (due_reports.size() != 0)
      flag_mismatch("results never delivered", due_reports.size(), 0);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
